/* sv/sfr_pkg.sv */
`default_nettype none
package sfr_pkg;

	typedef logic [7:0] byte_t;

	localparam int unsigned DATA_W = 64;
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned LEN_W  = 4;

	// Register index, taken from paddr[4:3] (registers sit on 8-byte spacing)
	typedef enum logic [1:0] {
		REG_PATTERN_BYTES      = 2'd0,
		REG_PATTERN_LENGTH     = 2'd1,
		REG_REPLACEMENT_BYTES  = 2'd2,
		REG_REPLACEMENT_LENGTH = 2'd3
	} reg_idx_t;

endpackage
`default_nettype wire

/* sv/sfr_in_if.sv */
`default_nettype none
interface sfr_in_if;
	logic          valid;
	logic          ready;
	sfr_pkg::byte_t in_byte;
	logic          in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface
`default_nettype wire

/* sv/sfr_out_if.sv */
`default_nettype none
interface sfr_out_if;
	logic          valid;
	logic          ready;
	sfr_pkg::byte_t out_byte;
	logic          has_byte;
	logic          out_last;

	modport source (output valid, output out_byte, output has_byte, output out_last,
		input ready);
	modport sink   (input valid, input out_byte, input has_byte, input out_last,
		output ready);
endinterface
`default_nettype wire

/* sv/stream_find_replace_core.sv */
`default_nettype none
// Streaming find-and-replace on a byte stream. Every leftmost, non-overlapping
// occurrence of the pattern (up to MAX_PATTERN bytes, set over APB) is replaced
// by the replacement text; the item marked in_last flushes the held bytes and
// the final result carries out_last. A string end that leaves nothing to send
// yields one result with has_byte low. An empty pattern passes bytes straight
// through; writing the pattern or its length drops any held bytes. Rate: one
// item per cycle while each item yields at most one result and egress keeps
// up. An item with more results (a replacement burst, or the string-end flush)
// stalls the input until only its last result is left to hand over. Each item
// is worked out combinationally between the window register and the burst
// register; a separate output register drives egress, so a new item is taken
// while a finished result waits there. Registers: 0x00 pattern bytes, 0x08
// pattern length, 0x10 replacement bytes, 0x18 replacement length; byte 0 of
// each text lives in bits 7:0; lengths above MAX_PATTERN count as MAX_PATTERN.
module stream_find_replace_core #(
	parameter int unsigned MAX_PATTERN = 8
) (
	input  wire                          clk,
	input  wire                          arst_n,
	sfr_in_if.sink                       ingress,
	sfr_out_if.source                    egress,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [sfr_pkg::ADDR_W-1:0]   paddr,
	input  wire  [sfr_pkg::DATA_W-1:0]   pwdata,
	output logic [sfr_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);

	localparam int unsigned CW = $clog2(MAX_PATTERN + 1);
	localparam int unsigned IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	// Configuration registers
	logic [sfr_pkg::DATA_W-1:0] pattern_bytes_q;
	logic [sfr_pkg::LEN_W-1:0]  pattern_length_q;
	logic [sfr_pkg::DATA_W-1:0] replacement_bytes_q;
	logic [sfr_pkg::LEN_W-1:0]  replacement_length_q;

	// Pending window
	sfr_pkg::byte_t win_q [MAX_PATTERN];
	logic [CW-1:0]  pend_cnt_q;

	// Burst register: results of the last accepted item, oldest in slot 0
	sfr_pkg::byte_t bst_bytes_q [MAX_PATTERN];
	logic [CW-1:0]  bst_cnt_q;
	logic           bst_has_q;
	logic           bst_last_q;

	// Output register
	logic           out_valid_q;
	sfr_pkg::byte_t out_byte_q;
	logic           out_has_q;
	logic           out_last_q;

	logic              cfg_wr;
	sfr_pkg::reg_idx_t cfg_idx;
	logic              drain;
	logic              accept;

	// Step logic
	logic [CW-1:0]  plen;
	logic [CW-1:0]  rlen;
	logic [IW-1:0]  c0;
	logic [CW-1:0]  c1;
	logic           full;
	logic           match;
	sfr_pkg::byte_t win_ins [MAX_PATTERN];
	sfr_pkg::byte_t win_nxt [MAX_PATTERN];
	sfr_pkg::byte_t res [MAX_PATTERN];
	logic [CW-1:0]  res_n;
	logic           res_has;
	logic [CW-1:0]  cnt_nxt;

	//---------------------------------------------------------------- APB
	assign pready  = 1'b1;
	assign cfg_idx = sfr_pkg::reg_idx_t'(paddr[4:3]);
	assign cfg_wr  = psel && penable && pwrite;

	always_comb begin
		unique case (cfg_idx)
			sfr_pkg::REG_PATTERN_BYTES:      prdata = pattern_bytes_q;
			sfr_pkg::REG_PATTERN_LENGTH:     prdata = {{(sfr_pkg::DATA_W - sfr_pkg::LEN_W){1'b0}},
				pattern_length_q};
			sfr_pkg::REG_REPLACEMENT_BYTES:  prdata = replacement_bytes_q;
			sfr_pkg::REG_REPLACEMENT_LENGTH: prdata = {{(sfr_pkg::DATA_W - sfr_pkg::LEN_W){1'b0}},
				replacement_length_q};
			default:                         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_bytes_q      <= '0;
			pattern_length_q     <= '0;
			replacement_bytes_q  <= '0;
			replacement_length_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				sfr_pkg::REG_PATTERN_BYTES:      pattern_bytes_q      <= pwdata;
				sfr_pkg::REG_PATTERN_LENGTH:     pattern_length_q     <= pwdata[sfr_pkg::LEN_W-1:0];
				sfr_pkg::REG_REPLACEMENT_BYTES:  replacement_bytes_q  <= pwdata;
				sfr_pkg::REG_REPLACEMENT_LENGTH: replacement_length_q <= pwdata[sfr_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	//---------------------------------------------------------------- handshake
	// Burst slot 0 moves to the output register when that register is free or
	// being taken. A new item is taken when the burst register is empty or is
	// handing over its final result in this cycle.
	assign drain        = (bst_cnt_q != '0) && (!out_valid_q || egress.ready);
	assign ingress.ready = (bst_cnt_q == '0) || ((bst_cnt_q == CW'(1)) && drain);
	assign accept       = ingress.valid && ingress.ready;

	//---------------------------------------------------------------- step
	always_comb begin
		match = 1'b1;
		plen  = (pattern_length_q > sfr_pkg::LEN_W'(MAX_PATTERN)) ? CW'(MAX_PATTERN)
			: CW'(pattern_length_q);
		rlen  = (replacement_length_q > sfr_pkg::LEN_W'(MAX_PATTERN)) ? CW'(MAX_PATTERN)
			: CW'(replacement_length_q);
		// Window is restarted if it already holds a full pattern's worth
		c0    = (pend_cnt_q >= plen) ? '0 : pend_cnt_q[IW-1:0];
		c1    = CW'(c0) + CW'(1);
		full  = (c1 == plen);

		for (int k = 0; k < MAX_PATTERN; k++) begin
			win_ins[k] = (IW'(k) == c0) ? ingress.in_byte : win_q[k];
			if ((CW'(k) < plen) && (win_ins[k] != pattern_bytes_q[8*k +: 8]))
				match = 1'b0;
		end

		res_has = 1'b1;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			res[k]     = win_ins[k];
			win_nxt[k] = win_ins[k];
		end

		priority if (plen == '0) begin
			// pass-through
			res[0]  = ingress.in_byte;
			res_n   = CW'(1);
			cnt_nxt = '0;
		end else if (full && match) begin
			for (int k = 0; k < MAX_PATTERN; k++)
				res[k] = replacement_bytes_q[8*k +: 8];
			res_n   = rlen;
			cnt_nxt = '0;
		end else if (full) begin
			// mismatch: oldest byte goes out; on string end the whole window does
			for (int k = 0; k < MAX_PATTERN - 1; k++)
				win_nxt[k] = win_ins[k+1];
			res_n   = ingress.in_last ? plen : CW'(1);
			cnt_nxt = ingress.in_last ? '0 : plen - CW'(1);
		end else begin
			res_n   = ingress.in_last ? c1 : '0;
			cnt_nxt = ingress.in_last ? '0 : c1;
		end

		// bare end marker
		if (ingress.in_last && (res_n == '0)) begin
			res[0]  = '0;
			res_has = 1'b0;
			res_n   = CW'(1);
		end
	end

	//---------------------------------------------------------------- state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cnt_q <= '0;
		end else if (cfg_wr && ((cfg_idx == sfr_pkg::REG_PATTERN_BYTES) ||
				(cfg_idx == sfr_pkg::REG_PATTERN_LENGTH))) begin
			pend_cnt_q <= '0;
		end else if (accept) begin
			pend_cnt_q <= cnt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < MAX_PATTERN; k++)
				win_q[k] <= win_nxt[k];
		end
	end

	// burst register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_cnt_q  <= '0;
			bst_has_q  <= 1'b0;
			bst_last_q <= 1'b0;
		end else if (accept) begin
			bst_cnt_q  <= res_n;
			bst_has_q  <= res_has;
			bst_last_q <= ingress.in_last;
		end else if (drain) begin
			bst_cnt_q  <= bst_cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < MAX_PATTERN; k++)
				bst_bytes_q[k] <= res[k];
		end else if (drain) begin
			for (int k = 0; k < MAX_PATTERN - 1; k++)
				bst_bytes_q[k] <= bst_bytes_q[k+1];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (drain) begin
			out_valid_q <= 1'b1;
		end else if (egress.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			out_byte_q <= bst_bytes_q[0];
			out_has_q  <= bst_has_q;
			out_last_q <= bst_last_q && (bst_cnt_q == CW'(1));
		end
	end

	assign egress.valid    = out_valid_q;
	assign egress.out_byte = out_byte_q;
	assign egress.has_byte = out_has_q;
	assign egress.out_last = out_last_q;

	//---------------------------------------------------------------- checks
	// the window never holds MAX_PATTERN bytes between items
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_cnt_q < CW'(MAX_PATTERN))
		else $error("pending count out of range");

	// every string end produces at least one result
	a_last_yields: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ingress.in_last) |=> (bst_cnt_q != '0))
		else $error("string end produced no result");

	// a result without a byte is only the bare end marker
	a_bare_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_has_q) |-> (out_last_q && (out_byte_q == '0)))
		else $error("empty result that is not an end marker");

	// the burst register is never overwritten while results remain
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ((bst_cnt_q == '0) || ((bst_cnt_q == CW'(1)) && drain)))
		else $error("burst overrun");

endmodule
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;

	// Clock period is 4 ns. The run is stopped by a cycle counter well above the slowest
	// legal run: about 170 items, each giving up to 8 results, the receiver
	// stalling 16% of the time, one receiver hold-off and the drains between settings.
	localparam int unsigned LIMIT_CYCLES = 200000;
	localparam int unsigned HOLD_CYCLES  = 200;
	// Extra cycles after the last expected result before a register write or the end.
	// An item that only fills the window gives no result, so wait past the
	// window -> burst -> output pipe.
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned PHASES        = 7;
	localparam int unsigned PHASE_ITEMS   = 21;

	// One edited result as it leaves the block.
	typedef struct packed {
		sfr_pkg::byte_t out_byte;
		logic           has_byte;
		logic           out_last;
	} edit_t;

	// Stimulus table: register writes, items and a few control rows for the two sides.
	typedef enum logic [2:0] {
		ROW_CFG,    // register write plus read-back, block idle
		ROW_ITEM,   // one input item
		ROW_HOLD,   // receiver holds ready low for HOLD_CYCLES
		ROW_PAUSE,  // sender stops until every expected result has come
		ROW_QUIET   // value[0] = 1: neither side idles
	} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		sfr_pkg::reg_idx_t idx;
		logic [63:0]       value;
		sfr_pkg::byte_t    in_byte;
		logic              in_last;
		bit                typed;   // want holds the single result typed into the table
		edit_t             want;
	} row_t;

	logic clk;
	logic arst_n;

	sfr_in_if  in_ch();
	sfr_out_if out_ch();

	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [sfr_pkg::ADDR_W-1:0] paddr;
	logic [sfr_pkg::DATA_W-1:0] pwdata;
	logic [sfr_pkg::DATA_W-1:0] prdata;
	logic                       pready;

	stream_find_replace_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.ingress (in_ch),
		.egress  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// ---------------------------------------------------------------------
	// Predictor: own copy of the registers and the pending window.
	// ---------------------------------------------------------------------
	logic [63:0]    find_text;
	logic [3:0]     find_len;
	logic [63:0]    subst_text;
	logic [3:0]     subst_len;
	sfr_pkg::byte_t window_bytes [8];
	logic [3:0]     window_fill;

	edit_t step_edits[$];   // results of the item just accepted
	edit_t edited_q[$];     // results still to come out of the block, oldest first

	row_t rows[$];

	int unsigned mismatch_count = 0;
	int unsigned items_sent     = 0;
	int unsigned results_seen   = 0;
	int unsigned reg_writes     = 0;
	int unsigned cycle_count    = 0;

	bit hold_req = 1'b0;
	bit no_idle  = 1'b0;

	function automatic logic [3:0] clamp_len(input logic [3:0] len);
		return (len > 4'd8) ? 4'd8 : len;
	endfunction

	function automatic void apply_reg(input sfr_pkg::reg_idx_t idx, input logic [63:0] value);
		case (idx)
			sfr_pkg::REG_PATTERN_BYTES: begin
				find_text   = value;
				window_fill = '0;
			end
			sfr_pkg::REG_PATTERN_LENGTH: begin
				find_len    = value[3:0];
				window_fill = '0;
			end
			sfr_pkg::REG_REPLACEMENT_BYTES:  subst_text = value;
			sfr_pkg::REG_REPLACEMENT_LENGTH: subst_len  = value[3:0];
			default: ;
		endcase
	endfunction

	// Works out the results caused by one accepted item into step_edits.
	function automatic void edit_step(input sfr_pkg::byte_t b, input logic last);
		logic [3:0] plen;
		logic [3:0] rlen;
		bit         hit;
		edit_t      tail;
		plen = clamp_len(find_len);
		rlen = clamp_len(subst_len);
		step_edits.delete();
		// Empty pattern: straight through, nothing held.
		if (plen == 4'd0) begin
			window_fill = '0;
			step_edits.push_back('{b, 1'b1, last});
			return;
		end
		if (window_fill >= plen)
			window_fill = '0;
		window_bytes[window_fill[2:0]] = b;
		window_fill = window_fill + 4'd1;
		if (window_fill == plen) begin
			hit = 1'b1;
			for (int k = 0; k < plen; k++)
				if (window_bytes[k] != find_text[8*k +: 8])
					hit = 1'b0;
			if (hit) begin
				// Replacement burst; an empty replacement deletes the match.
				for (int k = 0; k < rlen; k++)
					step_edits.push_back('{subst_text[8*k +: 8], 1'b1, 1'b0});
				window_fill = '0;
			end else begin
				step_edits.push_back('{window_bytes[0], 1'b1, 1'b0});
				for (int k = 1; k < 8; k++)
					window_bytes[k-1] = window_bytes[k];
				window_fill = window_fill - 4'd1;
			end
		end
		if (last) begin
			// End of string: flush the window, mark the final result.
			for (int k = 0; k < window_fill; k++)
				step_edits.push_back('{window_bytes[k], 1'b1, 1'b0});
			window_fill = '0;
			if (step_edits.size() == 0) begin
				// Nothing left to send: bare end marker.
				step_edits.push_back('{8'h00, 1'b0, 1'b1});
			end else begin
				tail = step_edits.pop_back();
				tail.out_last = 1'b1;
				step_edits.push_back(tail);
			end
		end
	endfunction

	// ---------------------------------------------------------------------
	// Table builders
	// ---------------------------------------------------------------------
	function automatic void add_item(input sfr_pkg::byte_t b, input logic last);
		row_t r;
		r = '{kind: ROW_ITEM, idx: sfr_pkg::REG_PATTERN_BYTES, value: '0, in_byte: b,
			in_last: last, typed: 1'b0, want: '0};
		rows.push_back(r);
	endfunction

	function automatic void add_typed(input sfr_pkg::byte_t b, input logic last,
		input sfr_pkg::byte_t wb, input logic wh, input logic wl);
		row_t r;
		r = '{kind: ROW_ITEM, idx: sfr_pkg::REG_PATTERN_BYTES, value: '0, in_byte: b,
			in_last: last, typed: 1'b1, want: '{wb, wh, wl}};
		rows.push_back(r);
	endfunction

	function automatic void add_cfg(input sfr_pkg::reg_idx_t idx, input logic [63:0] value);
		row_t r;
		r = '{kind: ROW_CFG, idx: idx, value: value, in_byte: '0, in_last: 1'b0,
			typed: 1'b0, want: '0};
		rows.push_back(r);
	endfunction

	function automatic void add_ctl(input row_kind_t kind, input logic [63:0] value);
		row_t r;
		r = '{kind: kind, idx: sfr_pkg::REG_PATTERN_BYTES, value: value, in_byte: '0,
			in_last: 1'b0, typed: 1'b0, want: '0};
		rows.push_back(r);
	endfunction

	// Random phases: a fresh setting, then strings built mostly from whole
	// pattern copies, some broken copies (a prefix and a stray byte) and noise.
	function automatic void add_random_phase(input int unsigned phase);
		logic [63:0]    pat;
		logic [3:0]     plen;
		logic [3:0]     rlen;
		int unsigned    eff;
		int unsigned    cnt;
		int unsigned    r;
		int unsigned    len;
		bit             broken;
		bit             ends;
		sfr_pkg::byte_t chunk [9];
		pat = {$urandom, $urandom};
		r = $urandom_range(99);
		if (r < 10)
			plen = 4'd0;
		else if (r < 20)
			plen = 4'($urandom_range(9, 15));
		else if (r < 30)
			plen = 4'($urandom_range(5, 8));
		else
			plen = 4'($urandom_range(1, 4));
		rlen = ($urandom_range(99) < 10) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
		eff = (plen > 4'd8) ? 8 : int'(plen);

		add_ctl(ROW_QUIET, (phase == 0) ? 64'd1 : 64'd0);
		add_cfg(sfr_pkg::REG_PATTERN_BYTES, pat);
		add_cfg(sfr_pkg::REG_PATTERN_LENGTH, 64'(plen));
		add_cfg(sfr_pkg::REG_REPLACEMENT_BYTES, {$urandom, $urandom});
		add_cfg(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'(rlen));
		if (phase == 2)
			add_ctl(ROW_HOLD, '0);

		cnt = 0;
		while (cnt < PHASE_ITEMS) begin
			r = $urandom_range(99);
			broken = 1'b0;
			if (eff != 0 && r < 55) begin
				len = eff;
				for (int k = 0; k < len; k++)
					chunk[k] = pat[8*k +: 8];
			end else if (eff > 1 && r < 75) begin
				broken = 1'b1;
				len = $urandom_range(1, eff - 1);
				for (int k = 0; k < len; k++)
					chunk[k] = pat[8*k +: 8];
				chunk[len] = sfr_pkg::byte_t'($urandom_range(255));
				len = len + 1;
			end else begin
				len = 1;
				chunk[0] = ($urandom_range(1) == 1) ? pat[8*$urandom_range(7) +: 8]
					: sfr_pkg::byte_t'($urandom_range(255));
			end
			ends = ($urandom_range(99) < 25) || (cnt + len >= PHASE_ITEMS &&
				$urandom_range(99) < 80);
			for (int k = 0; k < len; k++)
				add_item(chunk[k], ends && (k == len - 1));
			cnt = cnt + len;
			if (phase == 4 && cnt >= PHASE_ITEMS / 2 && cnt - len < PHASE_ITEMS / 2)
				add_ctl(ROW_PAUSE, '0);
		end
	endfunction

	// ---------------------------------------------------------------------
	// Drivers (all start and end at a falling edge, no assignment in the
	// step they end on)
	// ---------------------------------------------------------------------
	task automatic wait_quiet();
		in_ch.valid <= 1'b0;
		while (edited_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write one register, then read it straight back.
	task automatic write_reg(input sfr_pkg::reg_idx_t idx, input logic [63:0] value);
		logic [63:0] readback;
		logic [63:0] want;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= sfr_pkg::ADDR_W'(idx) << 3;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		apply_reg(idx, value);
		reg_writes++;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		readback = prdata;
		want = (idx == sfr_pkg::REG_PATTERN_LENGTH || idx == sfr_pkg::REG_REPLACEMENT_LENGTH)
			? {60'd0, value[3:0]} : value;
		if (readback !== want) begin
			mismatch_count++;
			$display("%0t ERROR: read-back of %s expected %016h actual %016h",
				$realtime, idx.name(), want, readback);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_item(input row_t r);
		while (!no_idle && $urandom_range(99) < 16) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.in_byte <= r.in_byte;
		in_ch.in_last <= r.in_last;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		// Accepted: the predictor always runs so its window stays in step.
		edit_step(r.in_byte, r.in_last);
		if (r.typed)
			edited_q.push_back(r.want);
		else
			foreach (step_edits[i])
				edited_q.push_back(step_edits[i]);
		items_sent++;
		@(negedge clk);
	endtask

	// ---------------------------------------------------------------------
	// Clock, reset, receiver, checker, watchdog
	// ---------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Receiver: random stalls, quiet stretches, and one long hold-off that
	// backs the block up into its input.
	initial begin : receiver
		int unsigned hold_left;
		hold_left = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 16);
			end
		end
	end

	// Every result taken by the receiver is matched against the oldest expectation.
	initial begin : edit_checker
		edit_t got;
		edit_t want;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
				got = '{out_ch.out_byte, out_ch.has_byte, out_ch.out_last};
				if (edited_q.size() == 0) begin
					mismatch_count++;
					$display("%0t ERROR: unexpected result byte %02h has %0b last %0b",
						$realtime, got.out_byte, got.has_byte, got.out_last);
				end else begin
					want = edited_q.pop_front();
					results_seen++;
					if (got !== want) begin
						mismatch_count++;
						$display("%0t ERROR: expected byte %02h has %0b last %0b, actual byte %02h has %0b last %0b",
							$realtime, want.out_byte, want.has_byte, want.out_last,
							got.out_byte, got.has_byte, got.out_last);
					end
				end
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t timeout with %0d results outstanding", $realtime, edited_q.size());
		$display("Mismatches found");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------
	initial begin : main_seq
		arst_n        = 1'b0;
		in_ch.valid   = 1'b0;
		in_ch.in_byte = '0;
		in_ch.in_last = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;

		// Predictor matches the register reset state.
		find_text   = '0;
		find_len    = '0;
		subst_text  = '0;
		subst_len   = '0;
		window_fill = '0;
		foreach (window_bytes[i])
			window_bytes[i] = '0;

		// Directed part. After reset the pattern is empty: straight through.
		add_typed(8'h00, 1'b0, 8'h00, 1'b1, 1'b0);
		add_typed(8'hFF, 1'b1, 8'hFF, 1'b1, 1'b1);
		add_typed(8'hA5, 1'b1, 8'hA5, 1'b1, 1'b1);
		// "ab" -> "XYZ"
		add_cfg(sfr_pkg::REG_PATTERN_BYTES, 64'h6261);
		add_cfg(sfr_pkg::REG_PATTERN_LENGTH, 64'd2);
		add_cfg(sfr_pkg::REG_REPLACEMENT_BYTES, 64'h5A5958);
		add_cfg(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'd3);
		add_item(8'h78, 1'b0);  // x
		add_item(8'h61, 1'b0);  // a
		add_item(8'h62, 1'b0);  // b
		add_item(8'h79, 1'b1);  // y, flushes
		add_item(8'h61, 1'b0);
		add_item(8'h62, 1'b1);  // match at the end mark
		// Empty replacement: a match at the end mark leaves a bare end marker.
		add_cfg(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'd0);
		add_item(8'h61, 1'b0);
		add_typed(8'h62, 1'b1, 8'h00, 1'b0, 1'b1);
		// Over-long lengths clamp to eight; all-ones pattern, all-zero replacement.
		add_cfg(sfr_pkg::REG_PATTERN_BYTES, '1);
		add_cfg(sfr_pkg::REG_PATTERN_LENGTH, 64'd15);
		add_cfg(sfr_pkg::REG_REPLACEMENT_BYTES, '0);
		add_cfg(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'd15);
		for (int k = 0; k < 8; k++)
			add_item(8'hFF, k == 7);
		// Pattern change while bytes are held drops them.
		add_cfg(sfr_pkg::REG_PATTERN_LENGTH, 64'd3);
		add_cfg(sfr_pkg::REG_PATTERN_BYTES, 64'h332211);
		add_item(8'h11, 1'b0);
		add_item(8'h22, 1'b0);
		add_cfg(sfr_pkg::REG_PATTERN_BYTES, 64'h112233);
		add_typed(8'h33, 1'b1, 8'h33, 1'b1, 1'b1);
		add_cfg(sfr_pkg::REG_PATTERN_LENGTH, 64'd0);
		add_typed(8'h5A, 1'b1, 8'h5A, 1'b1, 1'b1);

		for (int unsigned p = 0; p < PHASES; p++)
			add_random_phase(p);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			case (rows[i].kind)
				ROW_CFG: begin
					wait_quiet();
					write_reg(rows[i].idx, rows[i].value);
				end
				ROW_ITEM:  send_item(rows[i]);
				ROW_HOLD:  hold_req = 1'b1;
				ROW_PAUSE: wait_quiet();
				ROW_QUIET: no_idle = rows[i].value[0];
				default: ;
			endcase
		end
		wait_quiet();

		$display("Sent %0d items through %0d register writes; %0d results checked in %0d cycles",
			items_sent, reg_writes, results_seen, cycle_count);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d errors", mismatch_count);
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

/* filelist.f */
sv/sfr_pkg.sv
sv/sfr_in_if.sv
sv/sfr_out_if.sv
sv/stream_find_replace_core.sv
bench/tb.sv
